@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files, included by the bus engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/i2cm_pkg.sv @@
// Shared types and constants of the I2C register master
package i2cm_pkg;
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_BURST = 2'd3;

  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_POLLS   = 1'b1;

  localparam logic [15:0] RESET_PHASE_TICKS = 16'd5;
  localparam logic [7:0]  RESET_ACK_POLLS   = 8'd50;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_RS0  = 5'd1;
  localparam logic [4:0] PH_S1   = 5'd2;
  localparam logic [4:0] PH_S2   = 5'd3;
  localparam logic [4:0] PH_S3   = 5'd4;
  localparam logic [4:0] PH_TX0  = 5'd5;
  localparam logic [4:0] PH_TX1  = 5'd6;
  localparam logic [4:0] PH_TX2  = 5'd7;
  localparam logic [4:0] PH_TX3  = 5'd8;
  localparam logic [4:0] PH_AW   = 5'd9;
  localparam logic [4:0] PH_AH1  = 5'd10;
  localparam logic [4:0] PH_AH2  = 5'd11;
  localparam logic [4:0] PH_AL   = 5'd12;
  localparam logic [4:0] PH_RX0  = 5'd13;
  localparam logic [4:0] PH_RX1  = 5'd14;
  localparam logic [4:0] PH_RX2  = 5'd15;
  localparam logic [4:0] PH_RX3  = 5'd16;
  localparam logic [4:0] PH_M0   = 5'd17;
  localparam logic [4:0] PH_M1   = 5'd18;
  localparam logic [4:0] PH_M2   = 5'd19;
  localparam logic [4:0] PH_M3   = 5'd20;
  localparam logic [4:0] PH_P0   = 5'd21;
  localparam logic [4:0] PH_P1   = 5'd22;
  localparam logic [4:0] PH_P2   = 5'd23;
  localparam logic [4:0] PH_E0   = 5'd24;
  localparam logic [4:0] PH_E1   = 5'd25;
  localparam logic [4:0] PH_E2   = 5'd26;

  localparam logic [2:0] ST_ADDRW = 3'd0;
  localparam logic [2:0] ST_REG   = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_ADDRR = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  // one tick as classified by the front part
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] data;
    logic [7:0] len;
    logic       sda;
  } tick_t;

  // one result
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       valid;
    logic [7:0] rbyte;
    logic       last;
    logic       busy;
    logic       done;
    logic       err;
  } res_t;
endpackage

@@ rtl/i2cm_front.sv @@
// Input side: clamps the read length and queues ticks for the bus engine
module i2cm_front #(
  parameter int MAX_LEN = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      mode,
  input  logic [6:0]      device_address,
  input  logic [7:0]      register_address,
  input  logic [7:0]      write_data,
  input  logic [7:0]      read_length,
  input  logic            sda_in,
  output logic            q_valid,
  input  logic            q_take,
  output i2cm_pkg::tick_t q_tick
);
  localparam logic [7:0] MaxLen = 8'(MAX_LEN);

  i2cm_pkg::tick_t in_tick;
  i2cm_pkg::tick_t slot [2];
  logic [1:0] cnt;
  logic       rd_ptr, wr_ptr;
  logic       do_push, do_pop;

  // classify: effective read length
  always_comb begin
    in_tick.mode     = mode;
    in_tick.dev      = device_address;
    in_tick.reg_addr = register_address;
    in_tick.data     = write_data;
    in_tick.sda      = sda_in;
    if (mode == i2cm_pkg::MODE_READ || read_length == 8'd0) in_tick.len = 8'd1;
    else if (read_length > MaxLen) in_tick.len = MaxLen;
    else in_tick.len = read_length;
  end

  assign full    = cnt[1];
  assign q_valid = cnt != 2'd0;
  assign q_tick  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // two-entry queue
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= in_tick;
    if (rst) begin
      cnt <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

@@ rtl/i2cm_engine.sv @@
// Bus engine: steps the I2C phase sequencer one tick per queued item
module i2cm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            q_valid,
  output logic            q_take,
  input  i2cm_pkg::tick_t q_tick,
  output logic            r_valid,
  input  logic            r_take,
  output i2cm_pkg::res_t  r_res
);
`include "assert_macros.svh"
  logic [15:0] phase_ticks;
  logic [7:0]  ack_polls;
  logic [4:0]  phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [2:0]  stage, stage_next;
  logic [1:0]  h_mode, h_mode_next;
  logic [6:0]  h_dev, h_dev_next;
  logic [7:0]  h_reg, h_reg_next;
  logic [7:0]  h_data, h_data_next;
  logic [7:0]  h_len, h_len_next;
  logic [15:0] pt;
  logic        step;
  i2cm_pkg::res_t res;

  // result register with room when empty or being drained
  assign step   = q_valid && (!r_valid || r_take);
  assign q_take = step;
  assign pt     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::RESET_PHASE_TICKS;
      ack_polls   <= i2cm_pkg::RESET_ACK_POLLS;
    end else if (cfg_we) begin
      if (cfg_index == i2cm_pkg::CFG_PHASE_TICKS) phase_ticks <= cfg_data;
      else ack_polls <= cfg_data[7:0];
    end
  end

  // drive levels and phase sequencing
  always_comb begin
    phase_next = phase; tick_count_next = tick_count; bit_index_next = bit_index;
    shift_byte_next = shift_byte; bytes_left_next = bytes_left;
    poll_count_next = poll_count; stage_next = stage;
    h_mode_next = h_mode; h_dev_next = h_dev; h_reg_next = h_reg;
    h_data_next = h_data; h_len_next = h_len;
    res = '0;
    case (phase)
      i2cm_pkg::PH_IDLE, i2cm_pkg::PH_S1, i2cm_pkg::PH_S2, i2cm_pkg::PH_TX1,
      i2cm_pkg::PH_TX2, i2cm_pkg::PH_AH1, i2cm_pkg::PH_AH2, i2cm_pkg::PH_RX1,
      i2cm_pkg::PH_RX2, i2cm_pkg::PH_M1, i2cm_pkg::PH_M2, i2cm_pkg::PH_P1,
      i2cm_pkg::PH_P2, i2cm_pkg::PH_E1, i2cm_pkg::PH_E2: res.scl = 1'b1;
      default: res.scl = 1'b0;
    endcase
    case (phase)
      i2cm_pkg::PH_S2, i2cm_pkg::PH_S3, i2cm_pkg::PH_P0, i2cm_pkg::PH_P1,
      i2cm_pkg::PH_E0, i2cm_pkg::PH_E1: res.sda = 1'b0;
      i2cm_pkg::PH_TX0, i2cm_pkg::PH_TX1, i2cm_pkg::PH_TX2,
      i2cm_pkg::PH_TX3: res.sda = shift_byte[7];
      i2cm_pkg::PH_M0, i2cm_pkg::PH_M1, i2cm_pkg::PH_M2,
      i2cm_pkg::PH_M3: res.sda = bytes_left <= 8'd1;
      default: res.sda = 1'b1;
    endcase
    if (phase == i2cm_pkg::PH_IDLE || phase > i2cm_pkg::PH_E2) begin
      phase_next = i2cm_pkg::PH_IDLE;
      if (q_tick.mode != i2cm_pkg::MODE_TICK) begin
        h_mode_next = q_tick.mode; h_dev_next = q_tick.dev;
        h_reg_next = q_tick.reg_addr; h_data_next = q_tick.data;
        h_len_next = q_tick.len; bytes_left_next = q_tick.len;
        stage_next = i2cm_pkg::ST_ADDRW; poll_count_next = 8'd0;
        tick_count_next = 16'd0; phase_next = i2cm_pkg::PH_S1;
      end
    end else if (tick_count + 16'd1 < pt) begin
      tick_count_next = tick_count + 16'd1;
    end else begin
      tick_count_next = 16'd0;
      case (phase)
        i2cm_pkg::PH_S3: begin
          shift_byte_next = {h_dev, stage == i2cm_pkg::ST_ADDRR};
          bit_index_next = 4'd0; phase_next = i2cm_pkg::PH_TX0;
        end
        i2cm_pkg::PH_TX3: begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next = bit_index + 4'd1;
          if (bit_index + 4'd1 >= 4'd8) begin
            poll_count_next = 8'd0; phase_next = i2cm_pkg::PH_AW;
          end else phase_next = i2cm_pkg::PH_TX0;
        end
        i2cm_pkg::PH_AW: begin
          if (!q_tick.sda) phase_next = i2cm_pkg::PH_AH1;
          else if (poll_count >= ack_polls) phase_next = i2cm_pkg::PH_E0;
          else poll_count_next = poll_count + 8'd1;
        end
        i2cm_pkg::PH_AL: begin
          if (stage == i2cm_pkg::ST_ADDRW) begin
            stage_next = i2cm_pkg::ST_REG; shift_byte_next = h_reg;
            bit_index_next = 4'd0; phase_next = i2cm_pkg::PH_TX0;
          end else if (stage == i2cm_pkg::ST_REG) begin
            if (h_mode == i2cm_pkg::MODE_WRITE) begin
              stage_next = i2cm_pkg::ST_DATA; shift_byte_next = h_data;
              bit_index_next = 4'd0; phase_next = i2cm_pkg::PH_TX0;
            end else begin
              stage_next = i2cm_pkg::ST_ADDRR; phase_next = i2cm_pkg::PH_RS0;
            end
          end else if (stage == i2cm_pkg::ST_DATA) begin
            phase_next = i2cm_pkg::PH_P0;
          end else begin
            stage_next = i2cm_pkg::ST_READ;
            if (bytes_left == 8'd0) bytes_left_next = (h_len == 8'd0) ? 8'd1 : h_len;
            shift_byte_next = 8'd0; bit_index_next = 4'd0;
            phase_next = i2cm_pkg::PH_RX0;
          end
        end
        i2cm_pkg::PH_RX1: begin
          shift_byte_next = {shift_byte[6:0], q_tick.sda};
          phase_next = i2cm_pkg::PH_RX2;
        end
        i2cm_pkg::PH_RX3: begin
          bit_index_next = bit_index + 4'd1;
          if (bit_index + 4'd1 >= 4'd8) begin
            res.valid = 1'b1; res.rbyte = shift_byte;
            res.last = bytes_left <= 8'd1; phase_next = i2cm_pkg::PH_M0;
          end else phase_next = i2cm_pkg::PH_RX0;
        end
        i2cm_pkg::PH_M3: begin
          if (bytes_left <= 8'd1) begin
            bytes_left_next = 8'd0; phase_next = i2cm_pkg::PH_P0;
          end else begin
            bytes_left_next = bytes_left - 8'd1; shift_byte_next = 8'd0;
            bit_index_next = 4'd0; phase_next = i2cm_pkg::PH_RX0;
          end
        end
        i2cm_pkg::PH_P2: begin
          res.done = 1'b1; phase_next = i2cm_pkg::PH_IDLE;
        end
        i2cm_pkg::PH_E2: begin
          res.done = 1'b1; res.err = 1'b1; phase_next = i2cm_pkg::PH_IDLE;
        end
        default: phase_next = phase + 5'd1;
      endcase
    end
    res.busy = phase_next != i2cm_pkg::PH_IDLE;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cm_pkg::PH_IDLE; tick_count <= 16'd0; bit_index <= 4'd0;
      shift_byte <= 8'd0; bytes_left <= 8'd0; poll_count <= 8'd0;
      stage <= i2cm_pkg::ST_ADDRW; h_mode <= 2'd0; h_dev <= 7'd0;
      h_reg <= 8'd0; h_data <= 8'd0; h_len <= 8'd0;
    end else if (step) begin
      phase <= phase_next; tick_count <= tick_count_next;
      bit_index <= bit_index_next; shift_byte <= shift_byte_next;
      bytes_left <= bytes_left_next; poll_count <= poll_count_next;
      stage <= stage_next; h_mode <= h_mode_next; h_dev <= h_dev_next;
      h_reg <= h_reg_next; h_data <= h_data_next; h_len <= h_len_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) r_res <= res;
    if (rst) r_valid <= 1'b0;
    else if (step) r_valid <= 1'b1;
    else if (r_take) r_valid <= 1'b0;
  end

  `CHK_IMPL(a_err_done, clk, rst, r_valid && r_res.err, r_res.done, "error without done")
  `CHK_IMPL(a_last_valid, clk, rst, r_valid && r_res.last, r_res.valid,
            "last without byte")
  `CHK_NEXT(a_hold, clk, rst, r_valid && !r_take, r_valid && $stable(r_res),
            "result lost while stalled")
endmodule

@@ rtl/i2c_register_master.sv @@
// Top level of the I2C register master
//   channel | handshake    | payload
//   input   | push / full  | mode, device_address, register_address, write_data,
//           |              | read_length, sda_in
//   result  | empty / pop  | scl_level, sda_level, byte_valid, read_byte, last_byte,
//           |              | busy_res, done_res, ack_error
//   config  | cfg_we       | cfg_index, cfg_data
// One tick is taken per cycle while the result register is empty or popped; input
// passes the queue, then the result register. A phase moves on after phase_ticks ticks.
// rst is synchronous; it clears queue, result register, sequencer; resets config.
// A full result register with pop low stalls the sequencer; the 2-deep queue
// then absorbs up to two ticks before full rises.
module i2c_register_master #(
  parameter int MAX_READ_LENGTH = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [6:0]  device_address,
  input  logic [7:0]  register_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  read_length,
  input  logic        sda_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl_level,
  output logic        sda_level,
  output logic        byte_valid,
  output logic [7:0]  read_byte,
  output logic        last_byte,
  output logic        busy_res,
  output logic        done_res,
  output logic        ack_error,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic            q_valid, q_take, r_valid;
  i2cm_pkg::tick_t q_tick;
  i2cm_pkg::res_t  r_res;

  i2cm_front #(.MAX_LEN(MAX_READ_LENGTH)) u_front (
    .clk, .rst, .push, .full, .mode, .device_address, .register_address,
    .write_data, .read_length, .sda_in, .q_valid, .q_take, .q_tick
  );

  i2cm_engine u_engine (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_take, .q_tick,
    .r_valid, .r_take(pop), .r_res
  );

  assign empty      = !r_valid;
  assign scl_level  = r_res.scl;
  assign sda_level  = r_res.sda;
  assign byte_valid = r_res.valid;
  assign read_byte  = r_res.rbyte;
  assign last_byte  = r_res.last;
  assign busy_res   = r_res.busy;
  assign done_res   = r_res.done;
  assign ack_error  = r_res.err;
endmodule
